// ===== src/dirq_pkg.sv =====
// shared types and constants for the dynamic int8 requantizer
// used by dirq_divider and dynamic_int8_requantizer_top, no dependencies
`timescale 1ns / 1ps

package dirq_pkg;

    // iterative divider sizes
    localparam int DVD_W = 44;
    localparam int DVS_W = 32;
    localparam int DCNT_W = $clog2(DVD_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DVD_W - 1);

    // request and result codes
    localparam logic FN_LOAD = 1'b0;
    localparam logic FN_READ = 1'b1;
    localparam logic RK_SCALE = 1'b0;
    localparam logic RK_QUANT = 1'b1;

    // arithmetic constants
    localparam logic [DVD_W-1:0] SCALE_DIVISOR = 44'd127;
    localparam logic [3:0] FOLD_STEPS = 4'd8;
    localparam logic [DVD_W-1:0] QMAX_MAG = 44'd127;
    localparam logic [DVD_W-1:0] QMIN_MAG = 44'd128;
    localparam logic [31:0] SCALE_SAT = 32'hFFFF_FFFF;
    localparam logic [30:0] MAG_SAT = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SGO,
        ST_FOLD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/dynamic_int8_requantizer_top.sv =====
// a load not marked last returns no result and leaves the input ready; a read that hits runs the
// 44-step divider by twice the maximum, a read at or past the count skips it, and a last load
// runs three multiply steps, then an 8-step fold for the divide by 127
// throughput: loads back to back; a read or a last load holds the input until its result
// is taken into the output register, which waits on m_axis_tready while it is full
// reset: count 0, maximum 1, batch open; the accumulator store is not cleared
`timescale 1ns / 1ps

module dynamic_int8_requantizer_top #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // acc_value[31:0], entry_index[43:32], weight_scale[75:44],
    // input_scale[107:76], zero pad[111:108]
    input  logic [111:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quant_value[7:0], res_scale[39:8]
    output logic [39:0]  m_axis_tdata,
    // result_kind
    output logic         m_axis_tuser
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IW = (CW > 12) ? CW : 12;
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_ENTRIES);

    // input fields
    logic        in_func;
    logic [31:0] in_acc;
    logic        in_last;
    logic [11:0] in_idx;
    logic [31:0] in_ws;
    logic [31:0] in_is;

    assign in_func = s_axis_tuser;
    assign in_acc  = s_axis_tdata[31:0];
    assign in_last = s_axis_tlast;
    assign in_idx  = s_axis_tdata[43:32];
    assign in_ws   = s_axis_tdata[75:44];
    assign in_is   = s_axis_tdata[107:76];

    dirq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  count_reg;
    logic [30:0]    max_reg;
    logic           closed_reg;
    logic [31:0]    ws_reg;
    logic [31:0]    is_reg;
    logic           hit_reg;
    logic           kind_reg;
    logic           neg_reg;
    logic [62:0]    p1_reg;
    logic [63:0]    prod_reg;
    logic [dirq_pkg::DVD_W-1:0] q_reg;
    logic [dirq_pkg::DVD_W-1:0] fold_reg;
    logic [3:0]     fold_cnt_reg;
    logic [31:0]    rd_data_reg;

    logic           out_valid_reg;
    logic [7:0]     out_quant_reg;
    logic [31:0]    res_scale_reg;
    logic           out_kind_reg;

    logic [31:0]    mem [MAX_ENTRIES];

    // control strobes
    logic take;
    logic take_load;
    logic take_read;
    logic out_load;
    logic q_zero_load;
    logic q_div_load;

    // load path
    logic [CW-1:0]  eff_count;
    logic [30:0]    eff_max;
    logic [31:0]    acc_mag;
    logic [30:0]    acc_sat;
    logic           has_room;
    logic           mem_we;
    logic [IW-1:0]  idx_ext;
    logic [IW-1:0]  count_ext;
    logic [AW-1:0]  rd_addr;

    // read path
    logic [31:0]    rd_mag;
    logic [dirq_pkg::DVD_W-1:0] rd_dividend;

    // shared multiplier
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    mul_p;

    // scale fold
    logic           fold_step;
    logic           fold_end;
    logic [dirq_pkg::DVD_W-1:0] fold_hi;
    logic [dirq_pkg::DVD_W-1:0] fold_sum;
    logic [dirq_pkg::DVD_W-1:0] fold_add;

    // result forming
    logic [8:0]     neg_mag;
    logic [8:0]     neg_val;
    logic [7:0]     quant_val;
    logic [31:0]    scale_val;

    dirq_pkg::div_req_t div_req;
    dirq_pkg::div_rsp_t div_rsp;

    assign s_axis_tready = (state_reg == dirq_pkg::ST_IDLE);

    assign take      = s_axis_tvalid && s_axis_tready;
    assign take_load = take && (in_func == dirq_pkg::FN_LOAD);
    assign take_read = take && (in_func == dirq_pkg::FN_READ);

    // a load after a closed batch starts a fresh one
    assign eff_count = closed_reg ? '0 : count_reg;
    assign eff_max   = closed_reg ? 31'd1 : max_reg;
    assign acc_mag   = in_acc[31] ? (~in_acc + 32'd1) : in_acc;
    assign acc_sat   = acc_mag[31] ? dirq_pkg::MAG_SAT : acc_mag[30:0];
    assign has_room  = eff_count < CNT_FULL;
    assign mem_we    = take_load && has_room;

    assign idx_ext   = IW'(in_idx);
    assign count_ext = IW'(count_reg);
    assign rd_addr   = idx_ext[AW-1:0];

    // the store write lands at the accept edge and any read is issued later,
    // so one request at a time needs no forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[eff_count[AW-1:0]] <= in_acc;
        if (take_read)
            rd_data_reg <= mem[rd_addr];
    end

    // read dividend: mag*254 + max, divisor 2*max
    assign rd_mag      = rd_data_reg[31] ? (~rd_data_reg + 32'd1) : rd_data_reg;
    assign rd_dividend = {4'd0, rd_mag, 8'd0} - {11'd0, rd_mag, 1'b0}
                         + {13'd0, max_reg};

    // 128*h + l = 127*h + (h + l): the quotient gathers h, the rest folds down
    assign fold_step = (state_reg == dirq_pkg::ST_FOLD) && (fold_cnt_reg != dirq_pkg::FOLD_STEPS);
    assign fold_end  = (state_reg == dirq_pkg::ST_FOLD) && (fold_cnt_reg == dirq_pkg::FOLD_STEPS);
    assign fold_hi   = {7'd0, fold_reg[dirq_pkg::DVD_W-1:7]};
    assign fold_sum  = fold_hi + {37'd0, fold_reg[6:0]};
    assign fold_add  = fold_step ? fold_hi
                     : {43'd0, (fold_reg >= dirq_pkg::SCALE_DIVISOR)};

    always_comb
    begin
        unique case (state_reg)
            dirq_pkg::ST_MUL0:
            begin
                mul_a = {1'b0, max_reg};
                mul_b = ws_reg;
            end
            dirq_pkg::ST_MUL1:
            begin
                mul_a = p1_reg[31:0];
                mul_b = is_reg;
            end
            default:
            begin
                mul_a = {1'b0, p1_reg[62:32]};
                mul_b = is_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        out_load        = 1'b0;
        q_zero_load     = 1'b0;
        q_div_load      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rd_dividend;
        div_req.divisor  = {max_reg, 1'b0};
        unique case (state_reg)
            dirq_pkg::ST_IDLE:
            begin
                if (take_read)
                    state_next = dirq_pkg::ST_RD;
                else if (take_load && in_last)
                    state_next = dirq_pkg::ST_MUL0;
            end
            dirq_pkg::ST_RD:
            begin
                if (hit_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = dirq_pkg::ST_DIV;
                end
                else
                begin
                    q_zero_load = 1'b1;
                    state_next  = dirq_pkg::ST_FIN;
                end
            end
            dirq_pkg::ST_MUL0:
                state_next = dirq_pkg::ST_MUL1;
            dirq_pkg::ST_MUL1:
                state_next = dirq_pkg::ST_MUL2;
            dirq_pkg::ST_MUL2:
                state_next = dirq_pkg::ST_SGO;
            // product over 127<<20: drop 20 bits, then fold by 127
            dirq_pkg::ST_SGO:
                state_next = dirq_pkg::ST_FOLD;
            dirq_pkg::ST_FOLD:
            begin
                if (fold_end)
                    state_next = dirq_pkg::ST_FIN;
            end
            dirq_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_div_load = 1'b1;
                    state_next = dirq_pkg::ST_FIN;
                end
            end
            dirq_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = dirq_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dirq_pkg::ST_IDLE;
        endcase
    end

    dirq_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dirq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            max_reg    <= 31'd1;
            closed_reg <= 1'b0;
        end
        else if (take_load)
        begin
            count_reg  <= has_room ? eff_count + 1'b1 : eff_count;
            max_reg    <= (has_room && (acc_sat > eff_max)) ? acc_sat : eff_max;
            closed_reg <= in_last;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            ws_reg   <= in_ws;
            is_reg   <= in_is;
            kind_reg <= dirq_pkg::RK_SCALE;
        end
        if (take_read)
        begin
            hit_reg  <= idx_ext < count_ext;
            kind_reg <= dirq_pkg::RK_QUANT;
        end
        if (state_reg == dirq_pkg::ST_RD)
            neg_reg <= rd_data_reg[31];
        if (state_reg == dirq_pkg::ST_MUL0)
            p1_reg <= mul_p[62:0];
        if (state_reg == dirq_pkg::ST_MUL1)
            prod_reg <= mul_p;
        // high partial product only reaches the upper word mod 2^64
        if (state_reg == dirq_pkg::ST_MUL2)
            prod_reg[63:32] <= prod_reg[63:32] + mul_p[31:0];
        if (state_reg == dirq_pkg::ST_SGO)
        begin
            fold_reg     <= prod_reg[63:20];
            fold_cnt_reg <= '0;
        end
        else if (fold_step)
        begin
            fold_reg     <= fold_sum;
            fold_cnt_reg <= fold_cnt_reg + 4'd1;
        end
        if (q_zero_load || (state_reg == dirq_pkg::ST_SGO))
            q_reg <= '0;
        else if (q_div_load)
            q_reg <= div_rsp.quotient;
        else if (state_reg == dirq_pkg::ST_FOLD)
            q_reg <= q_reg + fold_add;
    end

    // clamp and sign the quantized value, saturate the scale and raise a zero scale to one
    assign neg_mag   = (q_reg > dirq_pkg::QMIN_MAG) ? 9'd128 : q_reg[8:0];
    assign neg_val   = ~neg_mag + 9'd1;
    assign quant_val = neg_reg ? neg_val[7:0]
                     : ((q_reg > dirq_pkg::QMAX_MAG) ? 8'd127 : q_reg[7:0]);
    assign scale_val = (q_reg[dirq_pkg::DVD_W-1:32] != '0) ? dirq_pkg::SCALE_SAT
                     : ((q_reg == '0) ? 32'd1 : q_reg[31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= kind_reg;
            if (kind_reg == dirq_pkg::RK_SCALE)
            begin
                out_quant_reg <= 8'd0;
                res_scale_reg <= scale_val;
            end
            else
            begin
                out_quant_reg <= quant_val;
                res_scale_reg <= 32'd0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_scale_reg, out_quant_reg};
    assign m_axis_tuser  = out_kind_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count beyond store depth");

    a_max_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg != 31'd0)
        else $error("batch maximum reached zero");

    a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take_load && in_last) |=> (closed_reg && state_reg == dirq_pkg::ST_MUL0))
        else $error("last load did not close the batch");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dirq_pkg::ST_DIV && div_rsp.done) |=> state_reg == dirq_pkg::ST_FIN)
        else $error("divider result not taken");

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == dirq_pkg::RK_SCALE) |-> m_axis_tdata[39:8] != 32'd0)
        else $error("zero output scale");

endmodule

// ===== src/dirq_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle while busy
// depends on dirq_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module dirq_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  dirq_pkg::div_req_t req,
    output dirq_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [dirq_pkg::DCNT_W-1:0]   cnt_reg;
    logic [dirq_pkg::DVS_W-1:0]    rem_reg;
    logic [dirq_pkg::DVS_W-1:0]    dvs_reg;
    logic [dirq_pkg::DVD_W-1:0]    dq_reg;

    logic [dirq_pkg::DVS_W:0]      trial;
    logic                          fits;
    logic [dirq_pkg::DVS_W:0]      diff;
    logic [dirq_pkg::DVS_W-1:0]    rem_next;
    logic [dirq_pkg::DVD_W-1:0]    dq_next;

    // dividend shifts out of the top of dq_reg while quotient bits enter below
    assign trial    = {rem_reg, dq_reg[dirq_pkg::DVD_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[dirq_pkg::DVS_W-1:0] : trial[dirq_pkg::DVS_W-1:0];
    assign dq_next  = {dq_reg[dirq_pkg::DVD_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == dirq_pkg::DIV_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            dq_reg  <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

// ===== sim/dynamic_int8_requantizer_top_test.sv =====
// self-checking testbench for dynamic_int8_requantizer_top: directed table, then random
// batches under varying stream backpressure, checked against fixed values or a local predictor
// depends on dirq_pkg and dynamic_int8_requantizer_top
`timescale 1ns / 1ps

module dynamic_int8_requantizer_top_test;

    localparam int MAX_ENTRIES = 4096;
    localparam int QMAX = 127;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic        func;
        logic [31:0] acc;
        logic        last;
        logic [11:0] idx;
        logic [31:0] wt_scale;
        logic [31:0] act_scale;
    } request_t;

    typedef struct {
        logic        kind;
        logic [7:0]  qval;
        logic [31:0] scale;
    } result_t;

    typedef struct {
        request_t req;
        bit       fixed;
        result_t  want;
    } table_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tuser;

    // predictor state
    logic [31:0] acc_mem [MAX_ENTRIES];
    int          entry_cnt;
    logic [30:0] max_mag;
    bit          batch_closed;

    result_t     pending_results[$];
    table_row_t  directed_rows[$];

    int err_cnt;
    int cycle_cnt;
    int sent_cnt;
    int load_cnt;
    int read_cnt;
    int scale_seen;
    int quant_seen;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_gen;

    dynamic_int8_requantizer_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // magnitude of a two's complement accumulator, 0 .. 2^31
    function automatic logic [63:0] acc_magnitude(input logic [31:0] a);
        logic [31:0] neg;
        neg = ~a + 32'd1;
        return a[31] ? {32'd0, neg} : {32'd0, a};
    endfunction

    // updates the predictor state and returns 1 when the request yields a result
    function automatic bit predict_requant(input request_t r, output result_t res);
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] quo;
        logic [63:0] den;
        res.kind = dirq_pkg::RK_QUANT;
        res.qval = 8'd0;
        res.scale = 32'd0;
        if (r.func == dirq_pkg::FN_LOAD)
        begin
            if (batch_closed)
            begin
                entry_cnt = 0;
                max_mag = 31'd1;
                batch_closed = 1'b0;
            end
            if (entry_cnt < MAX_ENTRIES)
            begin
                mag = acc_magnitude(r.acc);
                if (mag > 64'(dirq_pkg::MAG_SAT))
                    mag = 64'(dirq_pkg::MAG_SAT);
                acc_mem[entry_cnt] = r.acc;
                entry_cnt++;
                if (mag[30:0] > max_mag)
                    max_mag = mag[30:0];
            end
            if (!r.last)
                return 1'b0;
            batch_closed = 1'b1;
            // product wraps at 64 bits before the divide
            prod = 64'(max_mag) * 64'(r.wt_scale);
            prod = prod * 64'(r.act_scale);
            quo = prod / (64'(QMAX) << 20);
            if (quo < 64'd1)
                quo = 64'd1;
            if (quo > 64'(dirq_pkg::SCALE_SAT))
                quo = 64'(dirq_pkg::SCALE_SAT);
            res.kind = dirq_pkg::RK_SCALE;
            res.scale = quo[31:0];
            return 1'b1;
        end
        if (int'(r.idx) < entry_cnt)
        begin
            mag = acc_magnitude(acc_mem[r.idx]);
            den = 64'(max_mag);
            // round half away from zero on the magnitude
            quo = (mag * 64'(2 * QMAX) + den) / (64'd2 * den);
            if (acc_mem[r.idx][31])
            begin
                if (quo > 64'd128)
                    quo = 64'd128;
                res.qval = 8'(-quo);
            end
            else
            begin
                if (quo > 64'(QMAX))
                    quo = 64'(QMAX);
                res.qval = quo[7:0];
            end
        end
        return 1'b1;
    endfunction

    task automatic send_request(input request_t r, input bit fixed = 1'b0,
                                input result_t want = '{default: '0});
        result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, r.act_scale, r.wt_scale, r.idx, r.acc};
        s_axis_tuser <= r.func;
        s_axis_tlast <= r.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_cnt++;
        if (r.func == dirq_pkg::FN_LOAD)
            load_cnt++;
        else
            read_cnt++;
        if (predict_requant(r, res))
            pending_results.push_back(fixed ? want : res);
    endtask

    function automatic logic [31:0] pick_acc();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(200) - 100;
            3, 4: return $urandom_range(65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(1 << 22);
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.func = 1'($urandom_range(1));
        r.acc = $urandom;
        r.last = ($urandom_range(3) == 0);
        r.idx = 12'($urandom);
        r.wt_scale = $urandom;
        r.act_scale = $urandom;
        return r;
    endfunction

    // reads mostly land on stored entries, some at or past the count
    task automatic read_some(input int n);
        request_t r;
        for (int i = 0; i < n; i++)
        begin
            r = random_request();
            r.func = dirq_pkg::FN_READ;
            if (entry_cnt > 0 && $urandom_range(5) != 0)
                r.idx = 12'($urandom_range(entry_cnt - 1));
            else if (entry_cnt < MAX_ENTRIES)
                r.idx = 12'($urandom_range(MAX_ENTRIES - 1, entry_cnt));
            send_request(r);
        end
    endtask

    task automatic random_batch();
        int len;
        request_t r;
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 64) : $urandom_range(24, 1);
        for (int i = 0; i < len; i++)
        begin
            r = random_request();
            r.func = dirq_pkg::FN_LOAD;
            r.acc = pick_acc();
            r.last = (i == len - 1);
            if (r.last)
            begin
                r.wt_scale = pick_scale();
                r.act_scale = pick_scale();
            end
            send_request(r);
            if ($urandom_range(15) == 0)
                read_some(1);
        end
        read_some($urandom_range(8, 1));
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = sent_cnt + n;
        while (sent_cnt < stop_at)
        begin
            if ($urandom_range(4) == 0)
                send_request(random_request());
            else
                random_batch();
        end
    endtask

    function automatic void add_row(input logic func, input logic [31:0] acc, input logic last,
                                    input logic [11:0] idx, input logic [31:0] ws,
                                    input logic [31:0] is_v, input bit fixed = 1'b0,
                                    input logic kind = dirq_pkg::RK_QUANT,
                                    input logic [7:0] qv = 8'd0,
                                    input logic [31:0] sc = 32'd0);
        table_row_t row;
        row.req = '{func, acc, last, idx, ws, is_v};
        row.fixed = fixed;
        row.want = '{kind, qv, sc};
        directed_rows.push_back(row);
    endfunction

    function automatic void build_table();
        // reads right after reset see an empty batch
        add_row(dirq_pkg::FN_READ, 32'h1234_5678, 1'b0, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd0);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b1, 12'hFFF, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd0);
        // all-zero batch, scale raised to its floor
        add_row(dirq_pkg::FN_LOAD, 32'd0, 1'b0, 12'd7, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'd0, 1'b1, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_SCALE, 8'd0, 32'd1);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd0);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd1, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd0);
        // extremes, most negative value, wrapping scale product
        add_row(dirq_pkg::FN_LOAD, 32'h7FFF_FFFF, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'h8000_0000, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'd1, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'hFFFF_FFFF, 1'b1, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd127);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd1, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd2, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd3, 32'd0, 32'd0);
        // exact halves round away from zero
        add_row(dirq_pkg::FN_LOAD, 32'd254, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'd1, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_LOAD, 32'hFFFF_FFFF, 1'b1, 12'd0, 32'h0010_0000, 32'h0010_0000);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd1, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd1);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd2, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'hFF);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd127);
        // reads while the batch is still open, then a saturating scale
        add_row(dirq_pkg::FN_LOAD, 32'd100, 1'b0, 12'd0, 32'd0, 32'd0);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd0, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd127);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd1, 32'd0, 32'd0, 1'b1,
                dirq_pkg::RK_QUANT, 8'd0);
        add_row(dirq_pkg::FN_LOAD, 32'h7FFF_FFFF, 1'b1, 12'd0, 32'hFFFF_FFFF, 32'd1, 1'b1,
                dirq_pkg::RK_SCALE, 8'd0, dirq_pkg::SCALE_SAT);
        add_row(dirq_pkg::FN_READ, 32'd0, 1'b0, 12'd0, 32'd0, 32'd0);
    endfunction

    // result side: random idling plus one long hold-off counted here
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_gen)
            begin
                hold_seen = hold_gen;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.qval = m_axis_tdata[7:0];
            got.scale = m_axis_tdata[39:8];
            if (got.kind == dirq_pkg::RK_SCALE)
                scale_seen++;
            else
                quant_seen++;
            if (pending_results.size() == 0)
            begin
                err_cnt++;
                $error("unexpected result: result_kind %0d quant_value %0d res_scale %0d",
                       got.kind, $signed(got.qval), got.scale);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                begin
                    err_cnt++;
                    $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                end
                if (got.qval !== want.qval)
                begin
                    err_cnt++;
                    $error("quant_value: expected %0d, got %0d",
                           $signed(want.qval), $signed(got.qval));
                end
                if (got.scale !== want.scale)
                begin
                    err_cnt++;
                    $error("res_scale: expected %0d, got %0d", want.scale, got.scale);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        err_cnt = 0;
        cycle_cnt = 0;
        sent_cnt = 0;
        load_cnt = 0;
        read_cnt = 0;
        scale_seen = 0;
        quant_seen = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 71;
        hold_gen = 0;
        entry_cnt = 0;
        max_mag = 31'd1;
        batch_closed = 1'b0;
        build_table();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        run_phase(575, 28, 71);
        run_phase(575, 71, 28);
        // long receiver stall while requests keep coming, then no idling at all
        hold_gen++;
        run_phase(550, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests: %0d loads, %0d reads", sent_cnt, load_cnt, read_cnt);
        $display("checked %0d batch scales and %0d quantized reads in %0d cycles",
                 scale_seen, quant_seen, cycle_cnt);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
